FILE: hdl/touch_event_tracker_core_macros.svh
// Assertion macros used by the touch event tracker top level.
`ifndef TOUCH_EVENT_TRACKER_CORE_MACROS_SVH
`define TOUCH_EVENT_TRACKER_CORE_MACROS_SVH

`ifndef SYNTH

// Checked on every clock edge outside reset.
`define TET_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("touch tracker assertion failed");

// Checked on every clock edge, reset included.
`define TET_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("touch tracker invariant failed");

`else

`define TET_ASSERT(lbl, prop)
`define TET_ASSERT_ALWAYS(lbl, prop)

`endif

`endif

FILE: hdl/tet_pkg.sv
// Types, codes and helper functions of the touch event tracker.
package tet_pkg;

  // Display geometry used for mirroring rotated coordinates.
  localparam int unsigned DisplayWidth  = 200;
  localparam int unsigned DisplayHeight = 228;
  localparam int unsigned CoordW        = 10;

  localparam logic [CoordW-1:0] WidthTop  = CoordW'(DisplayWidth - 1);
  localparam logic [CoordW-1:0] HeightTop = CoordW'(DisplayHeight - 1);

  // Operation codes.
  localparam logic [2:0] OP_PHYS    = 3'd0;
  localparam logic [2:0] OP_INJECT  = 3'd1;
  localparam logic [2:0] OP_GESTURE = 3'd2;
  localparam logic [2:0] OP_RESET   = 3'd3;
  localparam logic [2:0] OP_RELEASE = 3'd4;

  // Injected sample phases.
  localparam logic [1:0] PH_BEGIN = 2'd0;
  localparam logic [1:0] PH_MOVE  = 2'd1;
  localparam logic [1:0] PH_END   = 2'd2;

  // Gesture kinds.
  localparam logic [1:0] GK_TAP        = 2'd0;
  localparam logic [1:0] GK_DOUBLE_TAP = 2'd1;

  // Event classes and touch event kinds.
  localparam logic       CLS_TOUCH     = 1'b0;
  localparam logic       CLS_GESTURE   = 1'b1;
  localparam logic [1:0] EV_TOUCHDOWN  = 2'd0;
  localparam logic [1:0] EV_LIFTOFF    = 2'd1;
  localparam logic [1:0] EV_UPDATE     = 2'd2;

  // Configuration register indexes.
  localparam logic CFG_ENABLE = 1'b0;
  localparam logic CFG_ROTATE = 1'b1;

  typedef struct packed {
    logic [2:0]        opcode;
    logic              finger_down;
    logic [1:0]        inject_phase;
    logic [1:0]        gesture_kind;
    logic [CoordW-1:0] pos_x;
    logic [CoordW-1:0] pos_y;
  } in_item_t;

  typedef struct packed {
    logic              accepted;
    logic              event_present;
    logic              event_class;
    logic [1:0]        event_kind;
    logic [CoordW-1:0] event_x;
    logic [CoordW-1:0] event_y;
    logic              user_contact;
    logic              injection_available;
  } out_item_t;

  // Tracker state carried from one operation to the next.
  typedef struct packed {
    logic              contact_down;
    logic [CoordW-1:0] last_col;
    logic [CoordW-1:0] last_row;
    logic              injection_owner;
  } trk_state_t;

  // Mirror a coordinate about the display edge; out-of-range values give zero.
  function automatic logic [CoordW-1:0] mirror(input logic [CoordW-1:0] v,
                                               input logic [CoordW-1:0] top);
    return (v > top) ? '0 : (top - v);
  endfunction

endpackage

FILE: hdl/touch_event_tracker_core.sv
// Top level of the touch event tracker: input register, tracker state and result register.
// The tracker takes one operation per clock cycle while the result side does not stall,
// and returns exactly one result for each. An operation is captured in an input
// register; when it advances, the tracker state is updated and the result is loaded
// into the output register, so results keep the order of the operations. The sustained
// rate is set by the state update between the two registers. A new operation is taken
// while an earlier result still waits to be taken. Configuration writes (enable, rotation)
// take effect at the next clock edge and should be made while no operation is in flight.
`include "touch_event_tracker_core_macros.svh"

module touch_event_tracker_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  tet_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output tet_pkg::out_item_t out_data_o,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic               cfg_data_i
);

  logic                enable_q;
  logic                rotated_q;
  logic                in_valid_q;
  tet_pkg::in_item_t   in_item_q;
  logic                out_valid_q;
  tet_pkg::out_item_t  out_item_q;
  tet_pkg::trk_state_t state_q;
  tet_pkg::trk_state_t state_d;
  tet_pkg::out_item_t  result_d;
  logic                advance;

  // The held operation moves on when the result register is free or being drained.
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q  <= 1'b1;
      rotated_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tet_pkg::CFG_ENABLE: enable_q  <= cfg_data_i;
        tet_pkg::CFG_ROTATE: rotated_q <= cfg_data_i;
        default:             enable_q  <= enable_q;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_item_q <= in_data_i;
    end
  end

  // Operation logic.
  tet_step u_step (
    .state_i   (state_q),
    .item_i    (in_item_q),
    .enable_i  (enable_q),
    .rotated_i (rotated_q),
    .state_o   (state_d),
    .result_o  (result_d)
  );

  // Tracker state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_item_q <= result_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_item_q;

  // An injection always holds the contact down.
  `TET_ASSERT_ALWAYS(a_owner_implies_down, state_q.injection_owner |-> state_q.contact_down)

  // A liftoff touch event only arises while a finger is down.
  `TET_ASSERT(a_liftoff_needs_contact, advance && result_d.event_present && result_d.event_class == tet_pkg::CLS_TOUCH && result_d.event_kind == tet_pkg::EV_LIFTOFF |-> state_q.contact_down)

  // The availability flag of a result matches the state it left behind.
  `TET_ASSERT(a_avail_matches_state, advance |=> out_data_o.injection_available == (enable_q && (state_q.injection_owner || !state_q.contact_down)))

  // Results without an event carry zero event fields.
  `TET_ASSERT(a_empty_event_zero, out_valid_o && !out_data_o.event_present |-> out_data_o.event_x == '0 && out_data_o.event_y == '0 && out_data_o.event_kind == '0 && !out_data_o.user_contact && !out_data_o.event_class)

  // Input side stalls only when both registers are occupied.
  `TET_ASSERT(a_stall_only_when_full, !in_ready_o |-> in_valid_q && out_valid_q && !out_ready_i)

endmodule

FILE: hdl/tet_step.sv
// Next-state and result logic for one tracker operation.
module tet_step (
  input  tet_pkg::trk_state_t state_i,
  input  tet_pkg::in_item_t   item_i,
  input  logic                enable_i,
  input  logic                rotated_i,
  output tet_pkg::trk_state_t state_o,
  output tet_pkg::out_item_t  result_o
);

  logic [tet_pkg::CoordW-1:0] phys_x;
  logic [tet_pkg::CoordW-1:0] phys_y;
  logic                       do_sample;
  logic                       smp_down;
  logic                       smp_inj;
  logic [tet_pkg::CoordW-1:0] smp_x;
  logic [tet_pkg::CoordW-1:0] smp_y;

  // Physical samples and gestures are mirrored when the panel is rotated.
  assign phys_x = rotated_i ? tet_pkg::mirror(item_i.pos_x, tet_pkg::WidthTop)
                            : item_i.pos_x;
  assign phys_y = rotated_i ? tet_pkg::mirror(item_i.pos_y, tet_pkg::HeightTop)
                            : item_i.pos_y;

  always_comb begin
    tet_pkg::trk_state_t st;
    tet_pkg::out_item_t  res;
    st        = state_i;
    res       = '0;
    do_sample = 1'b0;
    smp_down  = 1'b0;
    smp_inj   = 1'b0;
    smp_x     = item_i.pos_x;
    smp_y     = item_i.pos_y;

    // Decode the operation and decide whether a sample is applied.
    unique case (item_i.opcode)
      tet_pkg::OP_PHYS: begin
        if (enable_i && !state_i.injection_owner) begin
          res.accepted = 1'b1;
          do_sample    = 1'b1;
          smp_down     = item_i.finger_down;
          smp_x        = phys_x;
          smp_y        = phys_y;
        end
      end
      tet_pkg::OP_INJECT: begin
        smp_inj = 1'b1;
        if (enable_i) begin
          if (item_i.inject_phase == tet_pkg::PH_BEGIN) begin
            if (!state_i.injection_owner && !state_i.contact_down) begin
              st.injection_owner = 1'b1;
              res.accepted       = 1'b1;
              do_sample          = 1'b1;
              smp_down           = 1'b1;
            end
          end else if (item_i.inject_phase == tet_pkg::PH_MOVE) begin
            if (state_i.injection_owner) begin
              res.accepted = 1'b1;
              do_sample    = 1'b1;
              smp_down     = 1'b1;
            end
          end else if (item_i.inject_phase == tet_pkg::PH_END) begin
            if (state_i.injection_owner) begin
              st.injection_owner = 1'b0;
              res.accepted       = 1'b1;
              do_sample          = 1'b1;
              smp_down           = 1'b0;
            end
          end
        end
      end
      tet_pkg::OP_GESTURE: begin
        if (enable_i && !state_i.injection_owner) begin
          res.accepted = 1'b1;
          if (item_i.gesture_kind == tet_pkg::GK_TAP ||
              item_i.gesture_kind == tet_pkg::GK_DOUBLE_TAP) begin
            res.event_present = 1'b1;
            res.event_class   = tet_pkg::CLS_GESTURE;
            res.event_kind    = item_i.gesture_kind;
            res.event_x       = phys_x;
            res.event_y       = phys_y;
            res.user_contact  = 1'b1;
          end
        end
      end
      tet_pkg::OP_RESET: begin
        st           = '0;
        res.accepted = 1'b1;
      end
      tet_pkg::OP_RELEASE: begin
        res.accepted = 1'b1;
        if (state_i.contact_down) begin
          res.event_present = 1'b1;
          res.event_class   = tet_pkg::CLS_TOUCH;
          res.event_kind    = tet_pkg::EV_LIFTOFF;
          res.event_x       = state_i.last_col;
          res.event_y       = state_i.last_row;
        end
        st.contact_down    = 1'b0;
        st.injection_owner = 1'b0;
      end
      default: begin
        res.accepted = 1'b0;
      end
    endcase

    // A sample gives touchdown or liftoff on a contact change, else a position update.
    if (do_sample) begin
      if (state_i.contact_down != smp_down) begin
        st.contact_down   = smp_down;
        st.last_col       = smp_x;
        st.last_row       = smp_y;
        res.event_present = 1'b1;
        res.event_class   = tet_pkg::CLS_TOUCH;
        res.event_kind    = smp_down ? tet_pkg::EV_TOUCHDOWN : tet_pkg::EV_LIFTOFF;
        res.event_x       = smp_x;
        res.event_y       = smp_y;
        res.user_contact  = smp_down && !smp_inj;
      end else if (smp_down && (smp_x != state_i.last_col ||
                                smp_y != state_i.last_row)) begin
        st.last_col       = smp_x;
        st.last_row       = smp_y;
        res.event_present = 1'b1;
        res.event_class   = tet_pkg::CLS_TOUCH;
        res.event_kind    = tet_pkg::EV_UPDATE;
        res.event_x       = smp_x;
        res.event_y       = smp_y;
      end
    end

    // Availability reflects the state after this operation.
    res.injection_available = enable_i && (st.injection_owner || !st.contact_down);

    state_o  = st;
    result_o = res;
  end

endmodule

FILE: tb/sv/tet_result_checker.sv
// Result checker for the touch event tracker: predicts every transfer in and compares results.
module tet_result_checker
  import tet_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_ready_i,
  input  in_item_t  in_data_i,
  input  logic      out_valid_i,
  input  logic      out_ready_i,
  input  out_item_t out_data_i,
  input  logic      cfg_we_i,
  input  logic      cfg_idx_i,
  input  logic      cfg_data_i,
  output int        fail_count_o,
  output int        results_due_o
);

  // Tracker state and register copies kept by the checker.
  logic              enabled_q;
  logic              rotated_q;
  logic              down_q;
  logic              owner_q;
  logic [CoordW-1:0] col_q;
  logic [CoordW-1:0] row_q;

  out_item_t pending_results[$];
  out_item_t want;
  int        fail_count = 0;
  int        results_due = 0;

  assign fail_count_o  = fail_count;
  assign results_due_o = results_due;

  // Mirror one coordinate; anything past the display edge folds to zero.
  function automatic logic [CoordW-1:0] flip(input logic [CoordW-1:0] v,
                                             input logic [CoordW-1:0] lim);
    if (v > lim) return '0;
    return lim - v;
  endfunction

  // Apply one contact sample to the tracker and fill in the touch event it causes.
  function automatic void take_sample(input logic down, input logic [CoordW-1:0] x,
                                      input logic [CoordW-1:0] y, input logic injected,
                                      inout out_item_t r);
    if (down_q != down) begin
      down_q          = down;
      col_q           = x;
      row_q           = y;
      r.event_present = 1'b1;
      r.event_class   = CLS_TOUCH;
      r.event_kind    = down ? EV_TOUCHDOWN : EV_LIFTOFF;
      r.event_x       = x;
      r.event_y       = y;
      r.user_contact  = down && !injected;
    end else if (down && (x != col_q || y != row_q)) begin
      col_q           = x;
      row_q           = y;
      r.event_present = 1'b1;
      r.event_class   = CLS_TOUCH;
      r.event_kind    = EV_UPDATE;
      r.event_x       = x;
      r.event_y       = y;
    end
  endfunction

  // Work out the result of one operation and advance the tracker state.
  function automatic out_item_t track_op(input in_item_t op);
    out_item_t         r;
    logic [CoordW-1:0] cx;
    logic [CoordW-1:0] cy;
    logic              taken;
    r     = '0;
    cx    = op.pos_x;
    cy    = op.pos_y;
    taken = 1'b0;
    if (rotated_q) begin
      cx = flip(op.pos_x, WidthTop);
      cy = flip(op.pos_y, HeightTop);
    end
    case (op.opcode)
      OP_PHYS: begin
        if (enabled_q && !owner_q) begin
          r.accepted = 1'b1;
          take_sample(op.finger_down, cx, cy, 1'b0, r);
        end
      end
      OP_INJECT: begin
        if (enabled_q && op.inject_phase <= PH_END) begin
          if (op.inject_phase == PH_BEGIN) begin
            if (!owner_q && !down_q) begin
              owner_q = 1'b1;
              taken   = 1'b1;
            end
          end else if (owner_q) begin
            if (op.inject_phase == PH_END) owner_q = 1'b0;
            taken = 1'b1;
          end
          // Injected coordinates are never mirrored.
          if (taken) begin
            r.accepted = 1'b1;
            take_sample(op.inject_phase != PH_END, op.pos_x, op.pos_y, 1'b1, r);
          end
        end
      end
      OP_GESTURE: begin
        if (enabled_q && !owner_q) begin
          r.accepted = 1'b1;
          if (op.gesture_kind == GK_TAP || op.gesture_kind == GK_DOUBLE_TAP) begin
            r.event_present = 1'b1;
            r.event_class   = CLS_GESTURE;
            r.event_kind    = op.gesture_kind;
            r.event_x       = cx;
            r.event_y       = cy;
            r.user_contact  = 1'b1;
          end
        end
      end
      OP_RESET: begin
        down_q     = 1'b0;
        col_q      = '0;
        row_q      = '0;
        owner_q    = 1'b0;
        r.accepted = 1'b1;
      end
      OP_RELEASE: begin
        r.accepted = 1'b1;
        if (down_q) begin
          r.event_present = 1'b1;
          r.event_class   = CLS_TOUCH;
          r.event_kind    = EV_LIFTOFF;
          r.event_x       = col_q;
          r.event_y       = row_q;
        end
        down_q  = 1'b0;
        owner_q = 1'b0;
      end
      default: ;
    endcase
    r.injection_available = enabled_q && (owner_q || !down_q);
    return r;
  endfunction

  // Count one wrong field and report it.
  task automatic note_mismatch(input string field, input int unsigned exp_val,
                               input int unsigned act_val);
    fail_count++;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_val, act_val);
  endtask

  // Compare results on their transfer, predict on each transfer in, track register writes.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q = 1'b1;
      rotated_q = 1'b0;
      down_q    = 1'b0;
      owner_q   = 1'b0;
      col_q     = '0;
      row_q     = '0;
      pending_results.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (pending_results.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result, expected none, actual %p", $time, out_data_i);
        end else begin
          want = pending_results.pop_front();
          if (out_data_i.accepted !== want.accepted)
            note_mismatch("accepted", want.accepted, out_data_i.accepted);
          if (out_data_i.event_present !== want.event_present)
            note_mismatch("event_present", want.event_present, out_data_i.event_present);
          if (out_data_i.event_class !== want.event_class)
            note_mismatch("event_class", want.event_class, out_data_i.event_class);
          if (out_data_i.event_kind !== want.event_kind)
            note_mismatch("event_kind", want.event_kind, out_data_i.event_kind);
          if (out_data_i.event_x !== want.event_x)
            note_mismatch("event_x", want.event_x, out_data_i.event_x);
          if (out_data_i.event_y !== want.event_y)
            note_mismatch("event_y", want.event_y, out_data_i.event_y);
          if (out_data_i.user_contact !== want.user_contact)
            note_mismatch("user_contact", want.user_contact, out_data_i.user_contact);
          if (out_data_i.injection_available !== want.injection_available)
            note_mismatch("injection_available", want.injection_available,
                          out_data_i.injection_available);
        end
      end
      if (in_valid_i && in_ready_i) pending_results.push_back(track_op(in_data_i));
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_ENABLE) enabled_q = cfg_data_i;
        else rotated_q = cfg_data_i;
      end
    end
    results_due = pending_results.size();
  end

endmodule

FILE: tb/sv/tb.sv
// Testbench top for the touch event tracker core: stimulus, flow control and verdict.
module tb;
  import tet_pkg::*;

  localparam int         OpTarget   = 1250;
  localparam int         CycleLimit = 400000;
  localparam logic [1:0] GkOther    = 2'd2;
  localparam logic [1:0] PhBad      = 2'd3;
  localparam logic [2:0] OpLast     = 3'd7;

  logic      clk_i     = 1'b0;
  logic      rst_ni    = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  logic      cfg_we    = 1'b0;
  logic      cfg_idx   = CFG_ENABLE;
  logic      cfg_data  = 1'b0;

  int   fail_count;
  int   results_due;
  int   cycle_count = 0;
  int   ops_counted = 0;
  int   send_calm   = 0;
  int   take_calm   = 0;

  touch_event_tracker_core DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  tet_result_checker result_chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_data),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .results_due_o(results_due)
  );

  // Free-running clock with a period of 10.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Hard stop in case the run hangs.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Idle cycles before the next transfer; now and then a calm stretch with none at all.
  function automatic int draw_gap(inout int calm);
    int g;
    g = 0;
    if (calm > 0) begin
      calm--;
    end else begin
      g = $urandom_range(0, 13);
      if ($urandom_range(0, 24) == 0) calm = $urandom_range(10, 40);
    end
    return g;
  endfunction

  // Coordinate biased toward zero, the display edge, just past it, and the field maximum.
  function automatic logic [CoordW-1:0] pick_coord(input int unsigned span);
    case ($urandom_range(0, 7))
      0: return '0;
      1: return CoordW'(span - 1);
      2: return CoordW'(span);
      3: return '1;
      4: return CoordW'($urandom_range(0, 1023));
      default: return CoordW'($urandom_range(0, span - 1));
    endcase
  endfunction

  function automatic in_item_t mk_op(input logic [2:0] opcode, input logic finger,
                                     input logic [1:0] phase, input logic [1:0] kind,
                                     input logic [CoordW-1:0] x, input logic [CoordW-1:0] y);
    in_item_t op;
    op.opcode       = opcode;
    op.finger_down  = finger;
    op.inject_phase = phase;
    op.gesture_kind = kind;
    op.pos_x        = x;
    op.pos_y        = y;
    return op;
  endfunction

  // Operation with every field random; the caller pins down what matters.
  function automatic in_item_t rand_op(input logic [2:0] opcode);
    return mk_op(opcode, 1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                 2'($urandom_range(0, 3)), pick_coord(DisplayWidth), pick_coord(DisplayHeight));
  endfunction

  // Present one operation and hold it until its transfer.
  task automatic send_op(input in_item_t op);
    int gap;
    gap = draw_gap(send_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= op;
    do @(posedge clk_i); while (!in_ready);
    ops_counted++;
  endtask

  // Drain all results, let the pipeline settle, then write both registers.
  task automatic write_regs(input logic enable, input logic rotate);
    in_valid <= 1'b0;
    @(negedge clk_i);
    while (results_due != 0) @(negedge clk_i);
    repeat (3) @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_ENABLE;
    cfg_data <= enable;
    @(posedge clk_i);
    cfg_idx  <= CFG_ROTATE;
    cfg_data <= rotate;
    @(posedge clk_i);
    cfg_we   <= 1'b0;
  endtask

  // Result side: random stalls between transfers.
  initial begin : drain_results
    int stall;
    @(posedge rst_ni);
    forever begin
      stall = draw_gap(take_calm);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready <= 1'b1;
      do @(posedge clk_i); while (!out_valid);
    end
  end

  // Operation side: directed cases, then random phases under changing register settings.
  initial begin : stimulus
    in_item_t op;
    int       pick;
    int       moves;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Physical stroke, gestures and refusals at reset settings.
    send_op(mk_op(OP_PHYS, 1'b1, PH_BEGIN, GK_TAP, '0, '0));
    send_op(mk_op(OP_PHYS, 1'b1, PH_BEGIN, GK_TAP, '1, '1));
    send_op(mk_op(OP_PHYS, 1'b1, PH_BEGIN, GK_TAP, '1, '1));
    send_op(mk_op(OP_PHYS, 1'b0, PH_BEGIN, GK_TAP, 10'd5, 10'd7));
    send_op(mk_op(OP_GESTURE, 1'b0, PH_BEGIN, GK_TAP, '1, '0));
    send_op(mk_op(OP_GESTURE, 1'b0, PH_BEGIN, GK_DOUBLE_TAP, '0, '1));
    send_op(mk_op(OP_GESTURE, 1'b0, PH_BEGIN, GkOther, 10'd3, 10'd3));
    send_op(mk_op(OP_INJECT, 1'b0, PH_MOVE, GK_TAP, 10'd9, 10'd9));
    // Injection owns the sensor: physical samples and gestures are dropped.
    send_op(mk_op(OP_INJECT, 1'b0, PH_BEGIN, GK_TAP, 10'd10, 10'd20));
    send_op(mk_op(OP_INJECT, 1'b0, PH_BEGIN, GK_TAP, 10'd11, 10'd21));
    send_op(mk_op(OP_PHYS, 1'b1, PH_BEGIN, GK_TAP, 10'd40, 10'd40));
    send_op(mk_op(OP_GESTURE, 1'b0, PH_BEGIN, GK_TAP, 10'd40, 10'd40));
    send_op(mk_op(OP_INJECT, 1'b0, PH_MOVE, GK_TAP, 10'd30, 10'd40));
    send_op(mk_op(OP_INJECT, 1'b0, PhBad, GK_TAP, 10'd31, 10'd41));
    send_op(mk_op(OP_INJECT, 1'b0, PH_END, GK_TAP, 10'd30, 10'd40));
    // Begin refused while a finger is down, then forced release.
    send_op(mk_op(OP_PHYS, 1'b1, PH_BEGIN, GK_TAP, 10'd50, 10'd60));
    send_op(mk_op(OP_INJECT, 1'b0, PH_BEGIN, GK_TAP, 10'd1, 10'd2));
    send_op(mk_op(OP_RELEASE, 1'b0, PH_BEGIN, GK_TAP, '0, '0));
    send_op(mk_op(OP_RELEASE, 1'b0, PH_BEGIN, GK_TAP, '0, '0));
    send_op(mk_op(OP_INJECT, 1'b0, PH_BEGIN, GK_TAP, 10'd3, 10'd4));
    send_op(mk_op(OP_RESET, 1'b0, PH_BEGIN, GK_TAP, '0, '0));
    for (int c = int'(OP_RELEASE) + 1; c <= int'(OpLast); c++)
      send_op(mk_op(3'(c), 1'b1, PH_BEGIN, GK_TAP, 10'd7, 10'd7));

    // Rotation: edges, just past the edges, and unmirrored injection.
    write_regs(1'b1, 1'b1);
    send_op(mk_op(OP_PHYS, 1'b1, PH_BEGIN, GK_TAP, WidthTop, HeightTop));
    send_op(mk_op(OP_PHYS, 1'b1, PH_BEGIN, GK_TAP, '0, '0));
    send_op(mk_op(OP_PHYS, 1'b1, PH_BEGIN, GK_TAP, WidthTop + 1'b1, HeightTop + 1'b1));
    send_op(mk_op(OP_PHYS, 1'b0, PH_BEGIN, GK_TAP, '1, '1));
    send_op(mk_op(OP_GESTURE, 1'b0, PH_BEGIN, GK_TAP, '0, '0));
    send_op(mk_op(OP_INJECT, 1'b0, PH_BEGIN, GK_TAP, '0, '0));
    send_op(mk_op(OP_INJECT, 1'b0, PH_END, GK_TAP, '0, '0));

    // Disabled: samples, injections and gestures are ignored; reset and release still act.
    write_regs(1'b0, 1'b0);
    send_op(mk_op(OP_PHYS, 1'b1, PH_BEGIN, GK_TAP, 10'd8, 10'd8));
    send_op(mk_op(OP_INJECT, 1'b0, PH_BEGIN, GK_TAP, 10'd8, 10'd8));
    send_op(mk_op(OP_GESTURE, 1'b0, PH_BEGIN, GK_TAP, 10'd8, 10'd8));
    send_op(mk_op(OP_RELEASE, 1'b0, PH_BEGIN, GK_TAP, '0, '0));
    send_op(mk_op(OP_RESET, 1'b0, PH_BEGIN, GK_TAP, '0, '0));

    // Random phases of mostly well-formed strokes and injections.
    while (ops_counted < OpTarget) begin
      write_regs($urandom_range(0, 7) != 0, 1'($urandom_range(0, 1)));
      for (int k = 0; k < 40 && ops_counted < OpTarget; k++) begin
        pick = $urandom_range(0, 9);
        if (pick <= 3) begin
          // Physical stroke: down, some moves, up.
          op = rand_op(OP_PHYS);
          op.finger_down = 1'b1;
          send_op(op);
          moves = $urandom_range(0, 5);
          repeat (moves) begin
            if ($urandom_range(0, 2) != 0) begin
              op.pos_x = pick_coord(DisplayWidth);
              op.pos_y = pick_coord(DisplayHeight);
            end
            if ($urandom_range(0, 11) == 0) op.finger_down = 1'($urandom_range(0, 1));
            send_op(op);
            op.finger_down = 1'b1;
          end
          op = rand_op(OP_PHYS);
          op.finger_down = 1'b0;
          send_op(op);
        end else if (pick <= 6) begin
          // Injected gesture: begin, some moves, end.
          op = rand_op(OP_INJECT);
          op.inject_phase = PH_BEGIN;
          send_op(op);
          moves = $urandom_range(0, 5);
          repeat (moves) begin
            op.inject_phase = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(0, 3)) : PH_MOVE;
            if ($urandom_range(0, 2) != 0) begin
              op.pos_x = pick_coord(DisplayWidth);
              op.pos_y = pick_coord(DisplayHeight);
            end
            send_op(op);
          end
          if ($urandom_range(0, 7) == 0) op = rand_op(OP_PHYS);
          else op = rand_op(OP_INJECT);
          if (op.opcode == OP_INJECT) op.inject_phase = PH_END;
          send_op(op);
        end else if (pick == 7) begin
          send_op(rand_op(OP_GESTURE));
        end else if (pick == 8) begin
          send_op(rand_op(($urandom_range(0, 1) != 0) ? OP_RESET : OP_RELEASE));
        end else begin
          send_op(rand_op(3'($urandom_range(0, 7))));
        end
      end
    end

    // Wait for the last results, then give the verdict.
    in_valid <= 1'b0;
    @(negedge clk_i);
    while (results_due != 0) @(negedge clk_i);
    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
